### src/stack_cpu_instruction_step_unit_macros.svh
// assertion macros shared by the stack cpu rtl
`ifndef STACK_CPU_INSTRUCTION_STEP_UNIT_MACROS_SVH
`define STACK_CPU_INSTRUCTION_STEP_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack cpu check failed");

// next-cycle implication, checked outside reset
`define SCPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack cpu check failed");

`endif

### src/scpu_pkg.sv
// types and constants of the stack cpu
package scpu_pkg;

    typedef logic [15:0] t_word;
    typedef logic [12:0] t_pc;

    // write request into one stack
    typedef struct packed {
        logic  en;
        t_word data;
    } t_stk_wr;

    // instruction classes, bits 15:13 (4 to 7 are literals)
    localparam logic [2:0] CLS_JUMP    = 3'd0;
    localparam logic [2:0] CLS_ZBRANCH = 3'd1;
    localparam logic [2:0] CLS_CALL    = 3'd2;
    localparam logic [2:0] CLS_ALU     = 3'd3;

    // alu operation select, bits 11:8
    localparam logic [3:0] ALU_T     = 4'd0;
    localparam logic [3:0] ALU_N     = 4'd1;
    localparam logic [3:0] ALU_ADD   = 4'd2;
    localparam logic [3:0] ALU_AND   = 4'd3;
    localparam logic [3:0] ALU_OR    = 4'd4;
    localparam logic [3:0] ALU_XOR   = 4'd5;
    localparam logic [3:0] ALU_INV   = 4'd6;
    localparam logic [3:0] ALU_EQ    = 4'd7;
    localparam logic [3:0] ALU_LT    = 4'd8;
    localparam logic [3:0] ALU_SHR   = 4'd9;
    localparam logic [3:0] ALU_DEC   = 4'd10;
    localparam logic [3:0] ALU_R     = 4'd11;
    localparam logic [3:0] ALU_MEM   = 4'd12;
    localparam logic [3:0] ALU_SHL   = 4'd13;
    localparam logic [3:0] ALU_DEPTH = 4'd14;
    localparam logic [3:0] ALU_ULT   = 4'd15;

    // stack pointer delta codes
    localparam logic [1:0] DELTA_NONE = 2'd0;
    localparam logic [1:0] DELTA_INC  = 2'd1;
    localparam logic [1:0] DELTA_DEC2 = 2'd2;
    localparam logic [1:0] DELTA_DEC1 = 2'd3;

    // alu instruction flag bits
    localparam int BIT_R_TO_PC  = 12;
    localparam int BIT_T_TO_N   = 7;
    localparam int BIT_T_TO_R   = 6;
    localparam int BIT_N_TO_MEM = 5;

    localparam t_word WORD_TRUE  = 16'hFFFF;
    localparam t_word WORD_FALSE = 16'h0000;

endpackage

### src/stack_cpu_instruction_step_unit.sv
// top level of the two-stack 16-bit cpu, one instruction per item
// an item passes from the input register to the result register; a result-side stall can hold it between them
// throughput: one item per cycle while the result side does not stall; the stacks' registered read of n and r is ready
// for the following instruction because its address comes from the new pointers
// reset (synchronous, active low): pc, top, pointers and stack valid bits cleared,
// so every stack entry reads as zero until written; no clearing pass
module stack_cpu_instruction_step_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [15:0] instruction, [31:16] read_data
    // result item
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata   // [12:0] next_pc, [27:13] data_address,
                                         // [43:28] write_data, [44] write_enable,
                                         // [60:45] top_value, [63:61] zero
);
    import scpu_pkg::*;

    localparam int PW = $clog2(STACK_DEPTH);
    localparam logic [PW:0] DEPTH_X = (PW + 1)'(STACK_DEPTH);
    localparam logic [PW:0] ADD_INC  = (PW + 1)'(1);
    localparam logic [PW:0] ADD_DEC2 = (PW + 1)'(STACK_DEPTH - 2);
    localparam logic [PW:0] ADD_DEC1 = (PW + 1)'(STACK_DEPTH - 1);

    // pointer step modulo the stack depth: one add and one compare-subtract
    function automatic logic [PW-1:0] f_step(input logic [PW-1:0] p, input logic [1:0] code);
        logic [PW:0] add;
        logic [PW:0] sum;
        case (code)
            DELTA_INC:  add = ADD_INC;
            DELTA_DEC2: add = ADD_DEC2;
            DELTA_DEC1: add = ADD_DEC1;
            default:    add = '0;
        endcase
        sum = {1'b0, p} + add;
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[PW-1:0];
    endfunction

    // input register
    logic  r_in_valid;
    t_word r_ins;
    t_word r_rd;

    // architectural state
    t_word         r_top;
    t_pc           r_pc;
    logic [PW-1:0] r_dp;
    logic [PW-1:0] r_rp;

    // result register
    logic  r_out_valid;
    t_pc   r_out_pc;
    logic [14:0] r_out_addr;
    t_word r_out_wdata;
    logic  r_out_we;
    t_word r_out_top;

    // execute stage signals
    logic          w_fire;
    logic [2:0]    w_cls;
    logic [12:0]   w_low;
    t_pc           w_pc_inc;
    t_word         w_n;
    t_word         w_r;
    t_word         w_alu;
    t_word         n_top;
    t_pc           n_pc;
    logic [PW-1:0] n_dp;
    logic [PW-1:0] n_rp;
    logic          n_we;
    logic          w_ds_we;
    logic          w_rs_we;
    logic [PW-1:0] w_ds_waddr;
    logic [PW-1:0] w_rs_waddr;
    t_word         w_rs_wdata;
    t_stk_wr       w_ds_wr;
    t_stk_wr       w_rs_wr;

    // the execute stage runs when an item waits and the result register is free
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_ins <= i_s_axis_tdata[15:0];
            r_rd  <= i_s_axis_tdata[31:16];
        end
    end

    assign w_cls    = r_ins[15:13];
    assign w_low    = r_ins[12:0];
    assign w_pc_inc = r_pc + 13'd1;

    scpu_alu u_alu (
        .i_sel    (r_ins[11:8]),
        .i_t      (r_top),
        .i_n      (w_n),
        .i_r      (w_r),
        .i_rd     (r_rd),
        .o_result (w_alu)
    );

    // instruction decode and next state
    always_comb begin
        n_top      = r_top;
        n_pc       = r_pc;
        n_dp       = r_dp;
        n_rp       = r_rp;
        n_we       = 1'b0;
        w_ds_we    = 1'b0;
        w_rs_we    = 1'b0;
        w_ds_waddr = r_dp;
        w_rs_waddr = r_rp;
        // call pushes pc+1 as a 16-bit value, so pc 0x1fff pushes 0x2000
        w_rs_wdata = {3'd0, r_pc} + 16'd1;
        case (w_cls)
            CLS_JUMP: begin
                n_pc = w_low;
            end
            CLS_ZBRANCH: begin
                n_dp  = f_step(r_dp, DELTA_DEC1);
                n_top = w_n;
                n_pc  = (r_top != 16'd0) ? w_pc_inc : w_low;
            end
            CLS_CALL: begin
                w_rs_we = 1'b1;
                n_rp    = f_step(r_rp, DELTA_INC);
                n_pc    = w_low;
            end
            CLS_ALU: begin
                n_pc       = w_low[BIT_R_TO_PC] ? w_r[12:0] : w_pc_inc;
                n_top      = w_alu;
                n_we       = w_low[BIT_N_TO_MEM];
                n_rp       = f_step(r_rp, w_low[3:2]);
                n_dp       = f_step(r_dp, w_low[1:0]);
                // t-to-n and t-to-r land on the new top of each stack
                w_ds_we    = w_low[BIT_T_TO_N];
                w_ds_waddr = f_step(n_dp, DELTA_DEC1);
                w_rs_we    = w_low[BIT_T_TO_R];
                w_rs_waddr = f_step(n_rp, DELTA_DEC1);
                w_rs_wdata = r_top;
            end
            default: begin
                // literal: push old top, load 15-bit value
                w_ds_we = 1'b1;
                n_top   = {1'b0, r_ins[14:0]};
                n_dp    = f_step(r_dp, DELTA_INC);
                n_pc    = w_pc_inc;
            end
        endcase
    end

    assign w_ds_wr.en   = w_fire && w_ds_we;
    assign w_ds_wr.data = r_top;
    assign w_rs_wr.en   = w_fire && w_rs_we;
    assign w_rs_wr.data = w_rs_wdata;

    // n and r for the next instruction are read below the new pointers
    scpu_stack #(.DEPTH(STACK_DEPTH)) u_data_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_wr    (w_ds_wr),
        .i_waddr (w_ds_waddr),
        .i_raddr (f_step(n_dp, DELTA_DEC1)),
        .o_rdata (w_n)
    );

    scpu_stack #(.DEPTH(STACK_DEPTH)) u_return_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_wr    (w_rs_wr),
        .i_waddr (w_rs_waddr),
        .i_raddr (f_step(n_rp, DELTA_DEC1)),
        .o_rdata (w_r)
    );

    // architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_pc  <= '0;
            r_dp  <= '0;
            r_rp  <= '0;
        end else if (w_fire) begin
            r_top <= n_top;
            r_pc  <= n_pc;
            r_dp  <= n_dp;
            r_rp  <= n_rp;
        end
    end

    // result register; memory port fields come from the state before the instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_pc    <= n_pc;
            r_out_addr  <= r_top[15:1];
            r_out_wdata <= w_n;
            r_out_we    <= n_we;
            r_out_top   <= n_top;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_top, r_out_we, r_out_wdata, r_out_addr, r_out_pc};

`include "stack_cpu_instruction_step_unit_macros.svh"

    // a jump lands exactly on its target
    `SCPU_ASSERT_NEXT(a_jump_target, i_clk, i_rst_n, w_fire && (w_cls == CLS_JUMP), r_pc == $past(w_low))
    // only alu instructions request a memory store
    `SCPU_ASSERT_NOW(a_store_only_alu, i_clk, i_rst_n, w_fire && (w_cls != CLS_ALU), !n_we)
    // a literal always leaves a top with the high bit clear
    `SCPU_ASSERT_NEXT(a_literal_top, i_clk, i_rst_n, w_fire && w_cls[2], !r_top[15])
    // without an executed instruction the pc and both stack pointers hold
    `SCPU_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !w_fire, $stable(r_pc) && $stable(r_dp) && $stable(r_rp))

endmodule

### src/scpu_alu.sv
// alu of the stack cpu: new top of stack from t, n, r and read data
module scpu_alu (
    input  logic [3:0]     i_sel,
    input  scpu_pkg::t_word i_t,
    input  scpu_pkg::t_word i_n,
    input  scpu_pkg::t_word i_r,
    input  scpu_pkg::t_word i_rd,
    output scpu_pkg::t_word o_result
);
    import scpu_pkg::*;

    logic w_big_shift;

    assign w_big_shift = (i_t[15:4] != 12'd0);

    always_comb begin
        case (i_sel)
            ALU_T:     o_result = i_t;
            ALU_N:     o_result = i_n;
            ALU_ADD:   o_result = i_t + i_n;
            ALU_AND:   o_result = i_t & i_n;
            ALU_OR:    o_result = i_t | i_n;
            ALU_XOR:   o_result = i_t ^ i_n;
            ALU_INV:   o_result = ~i_t;
            ALU_EQ:    o_result = (i_n == i_t) ? WORD_TRUE : WORD_FALSE;
            ALU_LT:    o_result = ($signed(i_n) < $signed(i_t)) ? WORD_TRUE : WORD_FALSE;
            ALU_SHR:   o_result = w_big_shift ? WORD_FALSE : (i_n >> i_t[3:0]);
            ALU_DEC:   o_result = i_t - 16'd1;
            ALU_R:     o_result = i_r;
            ALU_MEM:   o_result = i_rd;
            ALU_SHL:   o_result = w_big_shift ? WORD_FALSE : (i_n << i_t[3:0]);
            ALU_DEPTH: o_result = WORD_FALSE;
            ALU_ULT:   o_result = (i_n < i_t) ? WORD_TRUE : WORD_FALSE;
            default:   o_result = WORD_FALSE;
        endcase
    end

endmodule

### src/scpu_stack.sv
// one stack: memory with valid bits, registered read of the entry below the pointer
module scpu_stack #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  scpu_pkg::t_stk_wr i_wr,
    input  logic [AW-1:0]    i_waddr,
    input  logic [AW-1:0]    i_raddr,
    output scpu_pkg::t_word  o_rdata
);
    import scpu_pkg::*;

    t_word            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_word            r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    // unwritten entries read as zero; a write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rdata <= '0;
        end else if (i_en) begin
            if (i_wr.en) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_wr.en && (i_waddr == i_raddr)) begin
                r_rdata <= i_wr.data;
            end else if (r_valid[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/stack_cpu_step_checker.sv
// checker for the stack cpu: predicts each instruction step and compares the results
module stack_cpu_step_checker
    import scpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [31:0] i_in_tdata,   // [15:0] instruction, [31:16] read_data
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [63:0] i_out_tdata,  // [12:0] next_pc, [27:13] data_address,
                                      // [43:28] write_data, [44] write_enable,
                                      // [60:45] top_value
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] top_value;
        logic        write_enable;
        t_word       write_data;
        logic [14:0] data_address;
        t_pc         next_pc;
    } step_result_t;

    // shadow copy of the cpu state
    t_word        data_stk [32];
    t_word        ret_stk  [32];
    t_word        tos;
    t_pc          pc;
    logic [4:0]   dsp;
    logic [4:0]   rsp;
    step_result_t predicted_steps [$];

    function automatic logic [4:0] moved_pointer(logic [4:0] ptr, logic [1:0] code);
        case (code)
            DELTA_INC:  return ptr + 5'd1;
            DELTA_DEC2: return ptr - 5'd2;
            DELTA_DEC1: return ptr - 5'd1;
            default:    return ptr;
        endcase
    endfunction

    function automatic t_word alu_value(logic [3:0] sel, t_word t, t_word n, t_word r,
                                        t_word rd);
        case (sel)
            ALU_T:     return t;
            ALU_N:     return n;
            ALU_ADD:   return t + n;
            ALU_AND:   return t & n;
            ALU_OR:    return t | n;
            ALU_XOR:   return t ^ n;
            ALU_INV:   return ~t;
            ALU_EQ:    return (n == t) ? WORD_TRUE : WORD_FALSE;
            ALU_LT:    return ($signed(n) < $signed(t)) ? WORD_TRUE : WORD_FALSE;
            ALU_SHR:   return (t >= 16) ? WORD_FALSE : t_word'(n >> t[3:0]);
            ALU_DEC:   return t - 16'd1;
            ALU_R:     return r;
            ALU_MEM:   return rd;
            ALU_SHL:   return (t >= 16) ? WORD_FALSE : t_word'(n << t[3:0]);
            ALU_DEPTH: return WORD_FALSE;
            default:   return (n < t) ? WORD_TRUE : WORD_FALSE;
        endcase
    endfunction

    // advances the shadow state by one instruction and queues the expected result
    function automatic void execute_instruction(t_word ins, t_word rd);
        step_result_t res;
        t_word        n;
        t_word        r;
        t_word        old_t;
        t_pc          pc_next;
        n                = data_stk[dsp - 5'd1];
        r                = ret_stk[rsp - 5'd1];
        old_t            = tos;
        res.data_address = tos[15:1];
        res.write_data   = n;
        res.write_enable = 1'b0;
        pc_next          = pc + 13'd1;
        case (ins[15:13])
            CLS_JUMP: begin
                pc_next = ins[12:0];
            end
            CLS_ZBRANCH: begin
                if (old_t == 16'd0) begin
                    pc_next = ins[12:0];
                end
                dsp = dsp - 5'd1;
                tos = n;
            end
            CLS_CALL: begin
                ret_stk[rsp] = {3'b000, pc} + 16'd1;
                rsp          = rsp + 5'd1;
                pc_next      = ins[12:0];
            end
            CLS_ALU: begin
                if (ins[BIT_R_TO_PC]) begin
                    pc_next = r[12:0];
                end
                res.write_enable = ins[BIT_N_TO_MEM];
                tos = alu_value(ins[11:8], old_t, n, r, rd);
                rsp = moved_pointer(rsp, ins[3:2]);
                dsp = moved_pointer(dsp, ins[1:0]);
                if (ins[BIT_T_TO_N]) begin
                    data_stk[dsp - 5'd1] = old_t;
                end
                if (ins[BIT_T_TO_R]) begin
                    ret_stk[rsp - 5'd1] = old_t;
                end
            end
            default: begin
                data_stk[dsp] = old_t;
                dsp           = dsp + 5'd1;
                tos           = {1'b0, ins[14:0]};
            end
        endcase
        pc            = pc_next;
        res.next_pc   = pc;
        res.top_value = tos;
        predicted_steps.push_back(res);
    endfunction

    function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        step_result_t exp_r;
        step_result_t act_r;
        bit           ok;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                data_stk[i] = '0;
                ret_stk[i]  = '0;
            end
            tos = '0;
            pc  = '0;
            dsp = '0;
            rsp = '0;
            predicted_steps.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                execute_instruction(i_in_tdata[15:0], i_in_tdata[31:16]);
            end
            if (i_out_tvalid && i_out_tready) begin
                act_r = i_out_tdata[60:0];
                if (predicted_steps.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_tdata);
                    o_fail_count++;
                end else begin
                    exp_r = predicted_steps.pop_front();
                    ok  = field_ok("next_pc", 16'(exp_r.next_pc), 16'(act_r.next_pc));
                    ok &= field_ok("data_address", 16'(exp_r.data_address),
                                   16'(act_r.data_address));
                    ok &= field_ok("write_data", exp_r.write_data, act_r.write_data);
                    ok &= field_ok("write_enable", 16'(exp_r.write_enable),
                                   16'(act_r.write_enable));
                    ok &= field_ok("top_value", exp_r.top_value, act_r.top_value);
                    if (!ok) begin
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = predicted_steps.size();
    end

endmodule

### tb/sv/stack_cpu_instruction_step_unit_tb.sv
// testbench top for the stack cpu: drives instruction items and gives the verdict
module stack_cpu_instruction_step_unit_tb;
    import scpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] instruction, [31:16] read_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [12:0] next_pc, [27:13] data_address,
                                 // [43:28] write_data, [44] write_enable, [60:45] top_value
    int          fail_count;
    int          pending;
    // set during the middle of the random part: neither side idles then
    bit          calm = 1'b0;

    always #5 i_clk = ~i_clk;

    stack_cpu_instruction_step_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    stack_cpu_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: stalls about a quarter of the cycles, never while calm
    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    // alu instruction word from its fields
    function automatic t_word alu_word(logic [3:0] sel, logic r_to_pc, logic t_to_n,
                                       logic t_to_r, logic n_to_mem, logic [1:0] rdelta,
                                       logic [1:0] ddelta);
        t_word w;
        w                = {CLS_ALU, 13'd0};
        w[11:8]          = sel;
        w[BIT_R_TO_PC]   = r_to_pc;
        w[BIT_T_TO_N]    = t_to_n;
        w[BIT_T_TO_R]    = t_to_r;
        w[BIT_N_TO_MEM]  = n_to_mem;
        w[3:2]           = rdelta;
        w[1:0]           = ddelta;
        return w;
    endfunction

    function automatic t_word lit_word(logic [14:0] value);
        return {1'b1, value};
    endfunction

    function automatic t_word flow_word(logic [2:0] cls, t_pc target);
        return {cls, target};
    endfunction

    // offers one item at the falling edge, with a random gap first, and holds it until taken
    task automatic send_item(t_word ins, t_word rd);
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rd, ins};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // a random instruction, weighted towards literals and alu words so that
    // shifts see small amounts and the stacks move both ways and wrap
    function automatic t_word random_instruction();
        int    pick;
        t_word w;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            if ($urandom_range(0, 3) == 0) begin
                w = lit_word(15'($urandom_range(0, 20)));
            end else begin
                w = lit_word(15'($urandom));
            end
        end else if (pick < 45) begin
            w = flow_word(CLS_JUMP, t_pc'($urandom));
        end else if (pick < 55) begin
            w = flow_word(CLS_ZBRANCH, t_pc'($urandom));
        end else if (pick < 65) begin
            w = flow_word(CLS_CALL, t_pc'($urandom));
        end else begin
            // return through r only now and then
            w               = {CLS_ALU, 13'($urandom)};
            w[BIT_R_TO_PC]  = ($urandom_range(0, 3) == 0);
        end
        return w;
    endfunction

    initial begin
        t_word directed [$];
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // jump to the last pc, call from there so the return address is 0x2000
        directed.push_back(flow_word(CLS_JUMP, 13'h1FFF));
        directed.push_back(flow_word(CLS_CALL, 13'h0155));
        // largest literal, then a shift amount above fifteen
        directed.push_back(lit_word(15'h7FFF));
        directed.push_back(lit_word(15'd17));
        directed.push_back(alu_word(ALU_SHL, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        // n stays 0x7fff while t walks through the operations
        directed.push_back(alu_word(ALU_INV, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_ULT, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_XOR, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_LT, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_ADD, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_EQ, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_AND, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_OR, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_DEC, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_N, 0, 0, 0, 1, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_T, 0, 1, 1, 1, DELTA_INC, DELTA_INC));
        // in-range shift right
        directed.push_back(lit_word(15'd4));
        directed.push_back(alu_word(ALU_SHR, 0, 0, 0, 0, DELTA_NONE, DELTA_DEC1));
        directed.push_back(alu_word(ALU_MEM, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        directed.push_back(alu_word(ALU_R, 0, 0, 0, 0, DELTA_DEC1, DELTA_NONE));
        directed.push_back(alu_word(ALU_DEPTH, 0, 0, 0, 0, DELTA_NONE, DELTA_NONE));
        // branch on zero taken, then not taken
        directed.push_back(flow_word(CLS_ZBRANCH, 13'h0ABC));
        directed.push_back(lit_word(15'd1));
        directed.push_back(flow_word(CLS_ZBRANCH, 13'h1555));
        // return through r with every flag and both pointers dropping by two
        directed.push_back(alu_word(ALU_T, 1, 1, 1, 1, DELTA_DEC2, DELTA_DEC2));

        foreach (directed[i]) begin
            send_item(directed[i], (directed[i][11:8] == ALU_MEM) ? 16'hA5C3 : 16'($urandom));
        end

        for (int k = 0; k < 450; k++) begin
            calm = (k >= 150 && k < 260);
            send_item(random_instruction(), 16'($urandom));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then allow for the pipeline
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // timeout for the whole run
    initial begin
        #500_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/scpu_pkg.sv
src/scpu_alu.sv
src/scpu_stack.sv
src/stack_cpu_instruction_step_unit.sv
tb/sv/stack_cpu_step_checker.sv
tb/sv/stack_cpu_instruction_step_unit_tb.sv
